>>> rtl/mi4_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mi4_pkg;

  localparam int unsigned ENTRY_W = 16;
  localparam int unsigned NUM_ENTRIES = 16;
  localparam int unsigned THR_W = 63;
  localparam int unsigned RESULT_W = 32;

  typedef logic [NUM_ENTRIES-1:0][ENTRY_W-1:0] mat_t;

  typedef struct packed {
    logic valid;
    mat_t data;
  } mat_word_t;

endpackage
`default_nettype wire

>>> rtl/mi4_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mi4_front import mi4_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [ENTRY_W-1:0] entry_value_i,
  input  wire logic               queue_full_i,
  output mat_word_t               push_o
);

  logic [3:0]         count_q, count_d;
  logic [ENTRY_W-1:0] store_q [NUM_ENTRIES];
  logic               accept;

  // only the closing word of a matrix waits on the queue
  assign in_stall_o = (count_q == 4'd15) && queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign count_d    = count_q + 4'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_q[count_q] <= entry_value_i;
    end
  end

  always_comb begin
    push_o.valid = accept && (count_q == 4'd15);
    for (int i = 0; i < NUM_ENTRIES - 1; i++) begin
      push_o.data[i] = store_q[i];
    end
    push_o.data[NUM_ENTRIES-1] = entry_value_i;
  end

endmodule
`default_nettype wire

>>> rtl/mi4_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mi4_queue import mi4_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire mat_word_t push_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output mat_word_t      head_o
);

  mat_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.data  = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.valid) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      case ({push_i.valid, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      ent_q[wp_q] <= push_i.data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mi4_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mi4_back import mi4_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mat_word_t           head_i,
  output logic                     pop_o,
  input  wire logic [THR_W-1:0]    thr_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [RESULT_W-1:0]      result_value_o,
  output logic                     singular_o,
  output logic                     last_of_matrix_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COF  = 3'd1;
  localparam logic [2:0] S_DET  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [2:0] OP_MN_SET  = 3'd0;
  localparam logic [2:0] OP_MN_SUB  = 3'd1;
  localparam logic [2:0] OP_ACC_SET = 3'd2;
  localparam logic [2:0] OP_ACC_SUB = 3'd3;
  localparam logic [2:0] OP_ACC_ADD = 3'd4;

  localparam int unsigned NUM_W = 72;
  localparam logic [6:0] DIV_LAST = 7'(NUM_W - 1);

  typedef struct packed {
    logic [3:0] ia;
    logic [3:0] ib;
    logic [2:0] op;
  } step_t;

  // 3x3 determinant as nine multiply steps over the minor positions
  function automatic step_t step_info(input logic [3:0] s);
    step_t t;
    case (s)
      4'd0:    t = '{ia: 4'd4, ib: 4'd8, op: OP_MN_SET};
      4'd1:    t = '{ia: 4'd5, ib: 4'd7, op: OP_MN_SUB};
      4'd2:    t = '{ia: 4'd0, ib: 4'd0, op: OP_ACC_SET};
      4'd3:    t = '{ia: 4'd3, ib: 4'd8, op: OP_MN_SET};
      4'd4:    t = '{ia: 4'd5, ib: 4'd6, op: OP_MN_SUB};
      4'd5:    t = '{ia: 4'd1, ib: 4'd0, op: OP_ACC_SUB};
      4'd6:    t = '{ia: 4'd3, ib: 4'd7, op: OP_MN_SET};
      4'd7:    t = '{ia: 4'd4, ib: 4'd6, op: OP_MN_SUB};
      default: t = '{ia: 4'd2, ib: 4'd0, op: OP_ACC_ADD};
    endcase
    return t;
  endfunction

  // position k of the 3x3 minor that drops row r and column c
  function automatic logic [3:0] sub_idx(input logic [1:0] r, input logic [1:0] c,
                                         input logic [3:0] k);
    logic [1:0] r3, c3;
    case (k)
      4'd0:    begin r3 = 2'd0; c3 = 2'd0; end
      4'd1:    begin r3 = 2'd0; c3 = 2'd1; end
      4'd2:    begin r3 = 2'd0; c3 = 2'd2; end
      4'd3:    begin r3 = 2'd1; c3 = 2'd0; end
      4'd4:    begin r3 = 2'd1; c3 = 2'd1; end
      4'd5:    begin r3 = 2'd1; c3 = 2'd2; end
      4'd6:    begin r3 = 2'd2; c3 = 2'd0; end
      4'd7:    begin r3 = 2'd2; c3 = 2'd1; end
      default: begin r3 = 2'd2; c3 = 2'd2; end
    endcase
    if (r3 >= r) r3 = r3 + 2'd1;
    if (c3 >= c) c3 = c3 + 2'd1;
    return {r3, c3};
  endfunction

  logic [2:0]          state_q;
  logic [ENTRY_W-1:0]  mat_q [NUM_ENTRIES];
  logic signed [48:0]  cof_q [NUM_ENTRIES];
  logic signed [15:0]  opa_q;
  logic signed [32:0]  mn_q;
  logic signed [48:0]  acc_q;
  logic signed [66:0]  det_q;
  logic [65:0]         dmag_q;
  logic                dneg_q, sing_q;
  logic [3:0]          ci_q, step_q, cnt_q;
  logic                ph_q;
  logic [6:0]          dcnt_q;
  logic [NUM_W-1:0]    num_q;
  logic [65:0]         rem_q;
  logic [31:0]         quo_q;
  logic                ovf_q, neg_q;
  logic                out_valid_q, sing_out_q, last_q;
  logic [RESULT_W-1:0] result_q;

  step_t               st;
  logic [1:0]          rr, cc;
  logic [3:0]          mat_addr, cof_addr;
  logic signed [15:0]  mat_rd;
  logic signed [48:0]  cof_rd;
  logic signed [15:0]  mul_a;
  logic signed [48:0]  mul_b;
  logic signed [64:0]  prod;
  logic signed [48:0]  acc_next;
  logic signed [66:0]  det_mag;
  logic                sing_now;
  logic signed [48:0]  cof_mag;
  logic [66:0]         rem_sh;
  logic                rem_ge;
  logic [66:0]         rem_sub;
  logic [RESULT_W-1:0] div_val, emit_val;
  logic                out_free;

  assign rr = ci_q[3:2];
  assign cc = ci_q[1:0];
  assign st = step_info(step_q);

  always_comb begin
    case (state_q)
      S_COF:   mat_addr = ph_q ? sub_idx(rr, cc, st.ib) : sub_idx(rr, cc, st.ia);
      default: mat_addr = cnt_q;
    endcase
    case (state_q)
      S_LOAD:  cof_addr = {cnt_q[1:0], cnt_q[3:2]};
      default: cof_addr = cnt_q;
    endcase
  end

  assign mat_rd = $signed(mat_q[mat_addr]);
  assign cof_rd = cof_q[cof_addr];

  always_comb begin
    mul_a = (state_q == S_DET) ? mat_rd : opa_q;
    if (state_q == S_DET) begin
      mul_b = cof_rd;
    end else if (st.op == OP_MN_SET || st.op == OP_MN_SUB) begin
      mul_b = 49'(mat_rd);
    end else begin
      mul_b = 49'(mn_q);
    end
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (st.op)
      OP_ACC_SET: acc_next = prod[48:0];
      OP_ACC_SUB: acc_next = acc_q - prod[48:0];
      OP_ACC_ADD: acc_next = acc_q + prod[48:0];
      default:    acc_next = acc_q;
    endcase
  end

  assign det_mag  = det_q[66] ? -det_q : det_q;
  assign sing_now = (det_mag == 67'd0) ||
                    ((det_mag[66:63] == 4'd0) && (det_mag[62:0] < thr_i));
  assign cof_mag  = cof_rd[48] ? -cof_rd : cof_rd;

  // restoring divide, one quotient bit a cycle
  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, dmag_q};
  assign rem_sub = rem_sh - {1'b0, dmag_q};

  always_comb begin
    if (neg_q) begin
      div_val = (ovf_q || quo_q > 32'h8000_0000) ? 32'h8000_0000 : -quo_q;
    end else begin
      div_val = (ovf_q || quo_q[31]) ? 32'h7FFF_FFFF : quo_q;
    end
    if (sing_q) begin
      emit_val = {{8{mat_rd[15]}}, mat_rd, 8'd0};
    end else begin
      emit_val = div_val;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && head_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ci_q        <= 4'd0;
      step_q      <= 4'd0;
      ph_q        <= 1'b0;
      cnt_q       <= 4'd0;
      dcnt_q      <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            state_q <= S_COF;
            ci_q    <= 4'd0;
            step_q  <= 4'd0;
            ph_q    <= 1'b0;
          end
        end
        S_COF: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (step_q == 4'd8) begin
              step_q <= 4'd0;
              if (ci_q == 4'd15) begin
                state_q <= S_DET;
                cnt_q   <= 4'd0;
              end else begin
                ci_q <= ci_q + 4'd1;
              end
            end else begin
              step_q <= step_q + 4'd1;
            end
          end
        end
        S_DET: begin
          if (cnt_q == 4'd3) begin
            state_q <= S_CHK;
          end
          cnt_q <= cnt_q + 4'd1;
        end
        S_CHK: begin
          cnt_q   <= 4'd0;
          state_q <= sing_now ? S_EMIT : S_LOAD;
        end
        S_LOAD: begin
          dcnt_q  <= 7'd0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 7'd1;
          if (dcnt_q == DIV_LAST) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd15) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= sing_q ? S_EMIT : S_LOAD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            mat_q[i] <= head_i.data[i];
          end
        end
        det_q <= '0;
      end
      S_COF: begin
        if (!ph_q) begin
          opa_q <= mat_rd;
        end else begin
          case (st.op)
            OP_MN_SET: mn_q <= prod[32:0];
            OP_MN_SUB: mn_q <= mn_q - prod[32:0];
            default:   acc_q <= acc_next;
          endcase
          if (step_q == 4'd8) begin
            cof_q[ci_q] <= (rr[0] ^ cc[0]) ? -acc_next : acc_next;
          end
        end
      end
      S_DET: begin
        det_q <= det_q + {{2{prod[64]}}, prod};
      end
      S_CHK: begin
        dmag_q <= det_mag[65:0];
        dneg_q <= det_q[66];
        sing_q <= sing_now;
      end
      S_LOAD: begin
        num_q <= {cof_mag[47:0], 24'd0};
        neg_q <= cof_rd[48] ^ dneg_q;
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
      end
      S_DIV: begin
        num_q <= {num_q[NUM_W-2:0], 1'b0};
        rem_q <= rem_ge ? rem_sub[65:0] : rem_sh[65:0];
        quo_q <= {quo_q[30:0], rem_ge};
        ovf_q <= ovf_q | quo_q[31];
      end
      S_EMIT: begin
        if (out_free) begin
          result_q   <= emit_val;
          sing_out_q <= sing_q;
          last_q     <= (cnt_q == 4'd15);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign result_value_o   = result_q;
  assign singular_o       = sing_out_q;
  assign last_of_matrix_o = last_q;

endmodule
`default_nettype wire

>>> rtl/matrix_inverse_4x4_top.sv
// after the sixteenth word the back runs the cofactor pass, determinant sum and check,
// then the restoring divider for each result, which is skipped when the matrix is singular.
// throughput: one word a cycle into the front, save a closing word on a full queue; the back
// is paced by the single shared multiplier and the one-bit-a-cycle divider.
// a two-matrix queue lets the front keep loading while the back works.
// reset: asynchronous active low, clears counters and queue, threshold back to 1.
`timescale 1ns / 1ps
`default_nettype none
module matrix_inverse_4x4_top import mi4_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [THR_W-1:0]    cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [ENTRY_W-1:0]  entry_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [RESULT_W-1:0]      result_value_o,
  output logic                     singular_o,
  output logic                     last_of_matrix_o
);

  logic [THR_W-1:0] thr_q;
  mat_word_t        push, head;
  logic             queue_full, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  mi4_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .entry_value_i (entry_value_i),
    .queue_full_i  (queue_full),
    .push_o        (push)
  );

  mi4_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (queue_full),
    .head_o (head)
  );

  mi4_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .thr_i            (thr_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_value_o   (result_value_o),
    .singular_o       (singular_o),
    .last_of_matrix_o (last_of_matrix_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !queue_full)
    else $error("push into full queue");

  a_last_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_matrix_o && !out_stall_i |=> !(out_valid_o && last_of_matrix_o))
    else $error("two matrix ends back to back");

  a_sing_low_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> (result_value_o[7:0] == 8'd0))
    else $error("singular word not a widened entry");

endmodule
`default_nettype wire
